@@ sv/dsnf_pkg.sv @@
// Shared types, segmentation table and helper functions for the strip neighbor finder.
package dsnf_pkg;

  localparam int unsigned NumTypes       = 9;
  localparam int unsigned NumColumns     = 7;
  localparam int unsigned StripsPerBoard = 16;
  localparam int unsigned NumSlots       = 6;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [3:0] LastStrip   = 4'(StripsPerBoard - 1);
  localparam logic [2:0] LastColumn  = 3'(NumColumns - 1);
  // Element type whose first column does not exist
  localparam logic [3:0] GapType     = 4'd4;

  // Result slot order, which is also the emission order
  localparam int unsigned SlotBelow     = 0;
  localparam int unsigned SlotAbove     = 1;
  localparam int unsigned SlotLeft      = 2;
  localparam int unsigned SlotLeftPair  = 3;
  localparam int unsigned SlotRight     = 4;
  localparam int unsigned SlotRightPair = 5;

  typedef struct packed {
    logic [2:0] bp;
    logic [2:0] nbp;
    logic [4:0] nbp_count;
    logic [3:0] line_mask;
  } seg_entry_t;

  typedef struct packed {
    logic       found;
    logic [2:0] column;
    logic [1:0] line;
    logic [3:0] strip;
  } result_t;

  typedef struct packed {
    logic [NumSlots-1:0]           mask;
    result_t [NumSlots-1:0]        slot;
  } job_t;

  localparam seg_entry_t C_NONE     = '{bp: 3'd0, nbp: 3'd0, nbp_count: 5'd0,  line_mask: 4'b0000};
  localparam seg_entry_t C_LARGE    = '{bp: 3'd4, nbp: 3'd4, nbp_count: 5'd8,  line_mask: 4'b0001};
  localparam seg_entry_t C_LAST     = '{bp: 3'd4, nbp: 3'd4, nbp_count: 5'd16, line_mask: 4'b0001};
  localparam seg_entry_t C_MED_WIDE = '{bp: 3'd2, nbp: 3'd4, nbp_count: 5'd8,  line_mask: 4'b0011};
  localparam seg_entry_t C_MED_FINE = '{bp: 3'd2, nbp: 3'd2, nbp_count: 5'd16, line_mask: 4'b0011};
  localparam seg_entry_t C_QUAD     = '{bp: 3'd1, nbp: 3'd2, nbp_count: 5'd16, line_mask: 4'b1111};
  localparam seg_entry_t C_T3C0     = '{bp: 3'd1, nbp: 3'd2, nbp_count: 5'd16, line_mask: 4'b0111};
  localparam seg_entry_t C_T4C1     = '{bp: 3'd1, nbp: 3'd2, nbp_count: 5'd8,  line_mask: 4'b1111};
  localparam seg_entry_t C_T5C0     = '{bp: 3'd1, nbp: 3'd2, nbp_count: 5'd16, line_mask: 4'b1110};

  localparam seg_entry_t SEG_TABLE [NumTypes][NumColumns] = '{
    '{C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LAST},
    '{C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_LAST},
    '{C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_WIDE, C_LAST},
    '{C_T3C0, C_QUAD, C_QUAD, C_MED_FINE, C_MED_FINE, C_MED_WIDE, C_LAST},
    '{C_NONE, C_T4C1, C_QUAD, C_MED_FINE, C_MED_FINE, C_MED_WIDE, C_LAST},
    '{C_T5C0, C_QUAD, C_QUAD, C_MED_FINE, C_MED_FINE, C_MED_WIDE, C_LAST},
    '{C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_FINE, C_MED_WIDE, C_LAST},
    '{C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_MED_WIDE, C_LAST},
    '{C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LARGE, C_LAST}
  };

  // Table read; out-of-range addresses read as an empty entry
  function automatic seg_entry_t seg_lookup(logic [3:0] rtype, logic [2:0] col);
    seg_entry_t res;
    res = C_NONE;
    if (rtype < 4'(NumTypes) && col < 3'(NumColumns)) begin
      res = SEG_TABLE[rtype][col];
    end
    return res;
  endfunction

  function automatic logic line_ok(seg_entry_t e, logic [4:0] ln);
    return (ln < 5'd4) && e.line_mask[ln[1:0]];
  endfunction

  // Height rescaled by the pitch ratio; pitches are powers of two
  function automatic logic [8:0] scale_height(logic [5:0] h, logic [2:0] p, logic [2:0] np);
    logic [8:0] prod;
    logic [8:0] res;
    prod = {3'b000, h} * {6'b000000, p};
    case (np)
      3'd1:    res = prod;
      3'd2:    res = prod >> 1;
      3'd4:    res = prod >> 2;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic result_t make_result(logic [2:0] col, logic [1:0] ln, logic [3:0] st);
    result_t r;
    r.found  = 1'b1;
    r.column = col;
    r.line   = ln;
    r.strip  = st;
    return r;
  endfunction

endpackage

@@ sv/dsnf_front.sv @@
// Front end: table lookup and classification of one strip into a job of result slots.
module dsnf_front (
  input  logic [3:0]       rpc_line,
  input  logic             cathode,
  input  logic [2:0]       column,
  input  logic [1:0]       line,
  input  logic [3:0]       strip,
  output dsnf_pkg::job_t   job
);

  dsnf_pkg::seg_entry_t e;
  dsnf_pkg::seg_entry_t le;
  dsnf_pkg::seg_entry_t re;
  logic                 in_range;
  logic [5:0]           height;
  logic [8:0]           left_h;
  logic [8:0]           right_h;
  logic [2:0]           left_col;
  logic [2:0]           right_col;
  logic [4:0]           strip_up;
  logic [4:0]           strip_dn;

  // Own entry and both adjacent column entries
  assign left_col  = column - 3'd1;
  assign right_col = column + 3'd1;
  assign e         = dsnf_pkg::seg_lookup(rpc_line, column);
  assign le        = dsnf_pkg::seg_lookup(rpc_line, left_col);
  assign re        = dsnf_pkg::seg_lookup(rpc_line, right_col);
  assign in_range  = (rpc_line < 4'(dsnf_pkg::NumTypes)) &&
                     (column < 3'(dsnf_pkg::NumColumns));
  assign height    = {line, strip};
  assign left_h    = dsnf_pkg::scale_height(height, e.bp, le.bp);
  assign right_h   = dsnf_pkg::scale_height(height, e.bp, re.bp);
  assign strip_up  = {1'b0, strip} + 5'd1;
  assign strip_dn  = {1'b0, strip - 4'd1};

  // Slot fill
  always_comb begin
    job = '0;
    if (in_range) begin
      if (!cathode) begin
        // same column, below
        if (strip == 4'd0) begin
          if (line != 2'd0 && dsnf_pkg::line_ok(e, {3'b000, line - 2'd1})) begin
            job.mask[dsnf_pkg::SlotBelow] = 1'b1;
            job.slot[dsnf_pkg::SlotBelow] =
              dsnf_pkg::make_result(column, line - 2'd1, dsnf_pkg::LastStrip);
          end
        end else begin
          job.mask[dsnf_pkg::SlotBelow] = 1'b1;
          job.slot[dsnf_pkg::SlotBelow] = dsnf_pkg::make_result(column, line, strip - 4'd1);
        end
        // same column, above
        if (strip == dsnf_pkg::LastStrip) begin
          if (dsnf_pkg::line_ok(e, {3'b000, line} + 5'd1)) begin
            job.mask[dsnf_pkg::SlotAbove] = 1'b1;
            job.slot[dsnf_pkg::SlotAbove] =
              dsnf_pkg::make_result(column, line + 2'd1, 4'd0);
          end
        end else begin
          job.mask[dsnf_pkg::SlotAbove] = 1'b1;
          job.slot[dsnf_pkg::SlotAbove] = dsnf_pkg::make_result(column, line, strip + 4'd1);
        end
        // left column, rescaled
        if (column != 3'd0 && !(rpc_line == dsnf_pkg::GapType && column == 3'd1) &&
            le.bp != 3'd0 && dsnf_pkg::line_ok(le, left_h[8:4])) begin
          job.mask[dsnf_pkg::SlotLeft] = 1'b1;
          job.slot[dsnf_pkg::SlotLeft] =
            dsnf_pkg::make_result(left_col, left_h[5:4], left_h[3:0]);
          if (e.bp > le.bp) begin
            job.mask[dsnf_pkg::SlotLeftPair] = 1'b1;
            job.slot[dsnf_pkg::SlotLeftPair] =
              dsnf_pkg::make_result(left_col, left_h[5:4], left_h[3:0] ^ 4'd1);
          end
        end
        // right column, rescaled
        if (column != dsnf_pkg::LastColumn && re.bp != 3'd0 &&
            dsnf_pkg::line_ok(re, right_h[8:4])) begin
          job.mask[dsnf_pkg::SlotRight] = 1'b1;
          job.slot[dsnf_pkg::SlotRight] =
            dsnf_pkg::make_result(right_col, right_h[5:4], right_h[3:0]);
          if (e.bp > re.bp) begin
            job.mask[dsnf_pkg::SlotRightPair] = 1'b1;
            job.slot[dsnf_pkg::SlotRightPair] =
              dsnf_pkg::make_result(right_col, right_h[5:4], right_h[3:0] ^ 4'd1);
          end
        end
      end else begin
        // non-bending: left neighbor
        if (strip == 4'd0) begin
          if (!(column == 3'd0 || (column == 3'd1 && rpc_line == dsnf_pkg::GapType)) &&
              dsnf_pkg::line_ok(le, {3'b000, line}) && le.nbp_count != 5'd0) begin
            job.mask[dsnf_pkg::SlotBelow] = 1'b1;
            job.slot[dsnf_pkg::SlotBelow] =
              dsnf_pkg::make_result(left_col, line, 4'(le.nbp_count - 5'd1));
          end
        end else if (strip_dn >= e.nbp_count) begin
          if (column != dsnf_pkg::LastColumn) begin
            job.mask[dsnf_pkg::SlotBelow] = 1'b1;
            job.slot[dsnf_pkg::SlotBelow] = dsnf_pkg::make_result(right_col, line, 4'd0);
          end
        end else begin
          job.mask[dsnf_pkg::SlotBelow] = 1'b1;
          job.slot[dsnf_pkg::SlotBelow] = dsnf_pkg::make_result(column, line, strip - 4'd1);
        end
        // non-bending: right neighbor
        if (strip_up >= e.nbp_count) begin
          if (column != dsnf_pkg::LastColumn) begin
            job.mask[dsnf_pkg::SlotAbove] = 1'b1;
            job.slot[dsnf_pkg::SlotAbove] = dsnf_pkg::make_result(right_col, line, 4'd0);
          end
        end else begin
          job.mask[dsnf_pkg::SlotAbove] = 1'b1;
          job.slot[dsnf_pkg::SlotAbove] = dsnf_pkg::make_result(column, line, strip + 4'd1);
        end
      end
    end
    // no neighbor: one not-found result
    if (job.mask == '0) begin
      job.mask[dsnf_pkg::SlotBelow] = 1'b1;
      job.slot[dsnf_pkg::SlotBelow] = '0;
    end
  end

endmodule

@@ sv/dsnf_queue.sv @@
// Job queue between the front end and the result sequencer.
module dsnf_queue #(
  parameter int unsigned DEPTH = dsnf_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dsnf_pkg::job_t   push_job,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output dsnf_pkg::job_t   head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dsnf_pkg::job_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ sv/dsnf_back.sv @@
// Back end: walks the slots of one job and drives the registered result channel.
module dsnf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  dsnf_pkg::job_t   q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [2:0]       nb_column,
  output logic [1:0]       nb_line,
  output logic [3:0]       nb_strip,
  output logic             last
);

  localparam int unsigned NumSlots = dsnf_pkg::NumSlots;

  dsnf_pkg::job_t         job;
  logic                   busy;
  logic [NumSlots-1:0]    pick;
  logic                   pick_last;
  logic                   out_load;
  logic                   advance;
  dsnf_pkg::result_t      pick_res;

  // Lowest pending slot goes next
  always_comb begin
    pick     = '0;
    pick_res = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (job.mask[i]) begin
        pick     = '0;
        pick[i]  = 1'b1;
        pick_res = job.slot[i];
      end
    end
  end

  assign pick_last = ((job.mask & ~pick) == '0);
  assign out_load  = !out_valid || !out_stall;
  assign advance   = busy && out_load;
  assign q_pop     = q_not_empty && (!busy || (advance && pick_last));

  // Job register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (advance && pick_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end else if (advance) begin
      job.mask <= job.mask & ~pick;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      found     <= pick_res.found;
      nb_column <= pick_res.column;
      nb_line   <= pick_res.line;
      nb_strip  <= pick_res.strip;
      last      <= pick_last;
    end
  end

  // Checks
  a_busy_has_work: assert property (@(posedge clk) disable iff (rst) busy |-> (job.mask != '0))
    else $error("active job has no pending slot");
  a_single_pick: assert property (@(posedge clk) disable iff (rst) advance |-> $onehot(pick))
    else $error("slot pick not one-hot");
  a_pop_loads: assert property (@(posedge clk) disable iff (rst) q_pop |=> busy)
    else $error("popped job not loaded");
  a_more_stays: assert property (@(posedge clk) disable iff (rst)
    (advance && !pick_last) |=> busy)
    else $error("job dropped with slots pending");

endmodule

@@ sv/detector_strip_neighbour_finder_top.sv @@
// Top level of the strip neighbor finder: front end, job queue and result sequencer.
//
// Input channel (in_valid / in_stall): one strip address per transfer
// (rpc_line, cathode, column, line, strip). The front end looks up the fixed
// segmentation table and turns the strip into a job of up to six neighbor
// slots in the same cycle, which goes into a small job queue.
// Output channel (out_valid / out_stall): one neighbor per transfer
// (found, nb_column, nb_line, nb_strip, last). A strip without neighbors
// gives a single result with found low; last marks the final result of a strip.
// The first result of a strip passes through the job queue, the job register
// and the output register on its way out.
// Throughput: the sequencer sends one result per cycle while the receiver does
// not stall; a strip has one to six results, and the queue lets the next strip
// enter while the current one is still being sent.
// Receiver stall: the output register holds its result; the sequencer stops,
// the queue fills and in_stall rises when it is full.
// Reset: synchronous rst empties the queue and the output register.
module detector_strip_neighbour_finder_top #(
  parameter int unsigned QUEUE_DEPTH = dsnf_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  rpc_line,
  input  logic        cathode,
  input  logic [2:0]  column,
  input  logic [1:0]  line,
  input  logic [3:0]  strip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [2:0]  nb_column,
  output logic [1:0]  nb_line,
  output logic [3:0]  nb_strip,
  output logic        last
);

  dsnf_pkg::job_t new_job;
  dsnf_pkg::job_t head_job;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  logic           q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  dsnf_front u_front (
    .rpc_line (rpc_line),
    .cathode  (cathode),
    .column   (column),
    .line     (line),
    .strip    (strip),
    .job      (new_job)
  );

  dsnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (new_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  dsnf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .nb_column   (nb_column),
    .nb_line     (nb_line),
    .nb_strip    (nb_strip),
    .last        (last)
  );

endmodule

@@ bench/detector_strip_neighbour_finder_top_test.sv @@
// Self-checking testbench for the strip neighbor finder top level.
`timescale 1ns / 1ps

module detector_strip_neighbour_finder_top_test;

  // Plane codes carried on the cathode input
  localparam logic BendPlane    = 1'b0;
  localparam logic NonBendPlane = 1'b1;

  localparam int NumTypes   = 9;
  localparam int NumCols    = 7;
  localparam int LastCol    = 6;
  localparam int BoardSize  = 16;
  localparam int GapTypeIdx = 4;
  localparam int CycleLimit = 200000;
  localparam int DrainTail  = 10;

  // Segmentation entry: bending pitch, non-bending pitch, non-bending count, line mask
  typedef struct packed {
    logic [2:0] bend_pitch;
    logic [2:0] nonbend_pitch;
    logic [4:0] nonbend_count;
    logic [3:0] line_mask;
  } seg_t;

  localparam seg_t SegAbsent   = {3'd0, 3'd0, 5'd0,  4'b0000};
  localparam seg_t SegLarge    = {3'd4, 3'd4, 5'd8,  4'b0001};
  localparam seg_t SegOuter    = {3'd4, 3'd4, 5'd16, 4'b0001};
  localparam seg_t SegMedWide  = {3'd2, 3'd4, 5'd8,  4'b0011};
  localparam seg_t SegMedFine  = {3'd2, 3'd2, 5'd16, 4'b0011};
  localparam seg_t SegQuad     = {3'd1, 3'd2, 5'd16, 4'b1111};
  localparam seg_t SegLowThree = {3'd1, 3'd2, 5'd16, 4'b0111};
  localparam seg_t SegHalfQuad = {3'd1, 3'd2, 5'd8,  4'b1111};
  localparam seg_t SegUpThree  = {3'd1, 3'd2, 5'd16, 4'b1110};

  typedef struct packed {
    logic       found;
    logic [2:0] column;
    logic [1:0] line;
    logic [3:0] strip;
    logic       last;
  } neighbour_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] rpc_line;
  logic       cathode;
  logic [2:0] column;
  logic [1:0] line;
  logic [3:0] strip;
  logic       out_valid;
  logic       out_stall;
  logic       found;
  logic [2:0] nb_column;
  logic [1:0] nb_line;
  logic [3:0] nb_strip;
  logic       last;

  neighbour_t expected_neighbours[$];
  int         strip_result_count;
  int         mismatch_count;
  int         strips_sent;
  int         neighbours_checked;
  int         cycle_count;
  bit         idling_on;

  detector_strip_neighbour_finder_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rpc_line (rpc_line),
    .cathode  (cathode),
    .column   (column),
    .line     (line),
    .strip    (strip),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found    (found),
    .nb_column(nb_column),
    .nb_line  (nb_line),
    .nb_strip (nb_strip),
    .last     (last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Fixed segmentation of the detector, one entry per type and column
  function automatic seg_t segment_of(int t, int c);
    seg_t e;
    e = SegAbsent;
    if (c == LastCol) begin
      e = SegOuter;
    end else begin
      case (t)
        0, 8: e = SegLarge;
        1, 7: e = SegMedWide;
        2, 6: e = (c == 5) ? SegMedWide : SegMedFine;
        3, 4, 5: begin
          if (c == 5) e = SegMedWide;
          else if (c >= 3) e = SegMedFine;
          else if (c == 2) e = SegQuad;
          else if (c == 1) e = (t == GapTypeIdx) ? SegHalfQuad : SegQuad;
          else if (t == 3) e = SegLowThree;
          else if (t == 5) e = SegUpThree;
          else e = SegAbsent;
        end
        default: e = SegAbsent;
      endcase
    end
    return e;
  endfunction

  function automatic bit line_exists(seg_t e, int l);
    return l >= 0 && l < 4 && e.line_mask[l] == 1'b1;
  endfunction

  // Append one entry at the tail of the expected list
  function automatic void append_expected(neighbour_t n);
    expected_neighbours = {expected_neighbours, n};
  endfunction

  function automatic void add_neighbour(int c, int l, int s);
    neighbour_t n;
    n.found  = 1'b1;
    n.column = 3'(c);
    n.line   = 2'(l);
    n.strip  = 4'(s);
    n.last   = 1'b0;
    append_expected(n);
    strip_result_count++;
  endfunction

  // Expected neighbor list of one strip address, appended in emission order
  function automatic void predict_neighbours(logic [3:0] rtype, logic plane, logic [2:0] col,
                                             logic [1:0] ln, logic [3:0] st);
    int         t, c, l, s;
    int         p, nc, np, height, nl, ns, n, pn;
    seg_t       e, ne;
    neighbour_t tail;
    t = rtype;
    c = col;
    l = ln;
    s = st;
    strip_result_count = 0;
    if (t < NumTypes && c < NumCols) begin
      e = segment_of(t, c);
      if (plane == BendPlane) begin
        p = e.bend_pitch;
        // same column, below and above, crossing board lines at the edges
        if (s == 0) begin
          if (l > 0 && line_exists(e, l - 1)) add_neighbour(c, l - 1, BoardSize - 1);
        end else begin
          add_neighbour(c, l, s - 1);
        end
        if (s + 1 >= BoardSize) begin
          if (line_exists(e, l + 1)) add_neighbour(c, l + 1, 0);
        end else begin
          add_neighbour(c, l, s + 1);
        end
        // adjacent columns, rescaled by the pitch ratio
        for (int side = 0; side < 2; side++) begin
          if (side == 0 && c == 0) continue;
          nc = (side == 0) ? c - 1 : c + 1;
          if (nc >= NumCols || (t == GapTypeIdx && nc == 0)) continue;
          ne = segment_of(t, nc);
          np = ne.bend_pitch;
          if (np == 0) continue;
          height = (BoardSize * l + s) * p / np;
          nl = height / BoardSize;
          if (!line_exists(ne, nl)) continue;
          ns = height % BoardSize;
          add_neighbour(nc, nl, ns);
          if (p > np) add_neighbour(nc, nl, ns ^ 1);
        end
      end else begin
        n = e.nonbend_count;
        // left side, crossing into the previous column at strip zero
        if (s == 0) begin
          if (!(c == 0 || (c == 1 && t == GapTypeIdx))) begin
            ne = segment_of(t, c - 1);
            pn = ne.nonbend_count;
            if (line_exists(ne, l) && pn > 0) add_neighbour(c - 1, l, pn - 1);
          end
        end else if (s - 1 >= n) begin
          if (c != LastCol) add_neighbour(c + 1, l, 0);
        end else begin
          add_neighbour(c, l, s - 1);
        end
        // right side, crossing into the next column past the strip count
        if (s + 1 >= n) begin
          if (c != LastCol) add_neighbour(c + 1, l, 0);
        end else begin
          add_neighbour(c, l, s + 1);
        end
      end
    end
    if (strip_result_count == 0) begin
      tail = '0;
      tail.last = 1'b1;
      append_expected(tail);
    end else begin
      tail = expected_neighbours.pop_back();
      tail.last = 1'b1;
      append_expected(tail);
    end
  endfunction

  // One strip address per transfer; starts and returns at a falling edge
  task automatic send_strip(logic [3:0] rtype, logic plane, logic [2:0] col,
                            logic [1:0] ln, logic [3:0] st);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    rpc_line = rtype;
    cathode  = plane;
    column   = col;
    line     = ln;
    strip    = st;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    predict_neighbours(rtype, plane, col, ln, st);
    strips_sent++;
  endtask

  // Edges of every field and each corner of the segmentation
  task automatic test_directed_cases();
    send_strip(4'd0,  BendPlane,    3'd0, 2'd0, 4'd0);
    send_strip(4'd0,  BendPlane,    3'd6, 2'd0, 4'd15);
    send_strip(4'd3,  BendPlane,    3'd0, 2'd2, 4'd15);
    send_strip(4'd3,  BendPlane,    3'd1, 2'd3, 4'd15);
    send_strip(4'd5,  BendPlane,    3'd0, 2'd1, 4'd0);
    send_strip(4'd4,  BendPlane,    3'd0, 2'd0, 4'd5);
    send_strip(4'd4,  BendPlane,    3'd1, 2'd0, 4'd3);
    send_strip(4'd3,  BendPlane,    3'd2, 2'd3, 4'd7);
    send_strip(4'd3,  BendPlane,    3'd3, 2'd1, 4'd9);
    send_strip(4'd1,  BendPlane,    3'd5, 2'd1, 4'd8);
    send_strip(4'd0,  BendPlane,    3'd3, 2'd3, 4'd15);
    send_strip(4'd9,  BendPlane,    3'd2, 2'd1, 4'd4);
    send_strip(4'd15, NonBendPlane, 3'd6, 2'd3, 4'd15);
    send_strip(4'd2,  BendPlane,    3'd7, 2'd0, 4'd0);
    send_strip(4'd2,  NonBendPlane, 3'd7, 2'd2, 4'd3);
    send_strip(4'd0,  NonBendPlane, 3'd0, 2'd0, 4'd0);
    send_strip(4'd0,  NonBendPlane, 3'd3, 2'd0, 4'd0);
    send_strip(4'd0,  NonBendPlane, 3'd2, 2'd0, 4'd7);
    send_strip(4'd0,  NonBendPlane, 3'd6, 2'd0, 4'd15);
    send_strip(4'd0,  NonBendPlane, 3'd6, 2'd0, 4'd0);
    send_strip(4'd4,  NonBendPlane, 3'd1, 2'd0, 4'd0);
    send_strip(4'd4,  NonBendPlane, 3'd0, 2'd0, 4'd0);
    send_strip(4'd1,  NonBendPlane, 3'd2, 2'd0, 4'd12);
    send_strip(4'd5,  NonBendPlane, 3'd1, 2'd0, 4'd0);
    send_strip(4'd8,  NonBendPlane, 3'd5, 2'd3, 4'd8);
  endtask

  // Random addresses, mostly inside the table, with strips biased to the board edges
  task automatic test_random_addresses(int count);
    logic [3:0] t;
    logic       pl;
    logic [2:0] c;
    logic [1:0] l;
    logic [3:0] s;
    repeat (count) begin
      t  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      pl = 1'($urandom);
      c  = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      l  = 2'($urandom);
      s  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'd15 : 4'd0) : 4'($urandom);
      send_strip(t, pl, c, l, s);
    end
  endtask

  // Back-to-back transfers with neither side idling
  task automatic test_streaming(int count);
    idling_on = 1'b0;
    test_random_addresses(count);
  endtask

  function automatic void compare_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // Receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Result checking against the oldest expected neighbor
  always @(posedge clk) begin
    neighbour_t exp_n;
    if (!rst && out_valid && !out_stall) begin
      if (expected_neighbours.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, found, nb_column, nb_line, nb_strip, last);
        mismatch_count++;
      end else begin
        exp_n = expected_neighbours.pop_front();
        compare_field("found", exp_n.found, found);
        compare_field("nb_column", exp_n.column, nb_column);
        compare_field("nb_line", exp_n.line, nb_line);
        compare_field("nb_strip", exp_n.strip, nb_strip);
        compare_field("last", exp_n.last, last);
        neighbours_checked++;
      end
    end
  end

  // Timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, expected_neighbours.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    rpc_line           = '0;
    cathode            = BendPlane;
    column             = '0;
    line               = '0;
    strip              = '0;
    idling_on          = 1'b1;
    mismatch_count     = 0;
    strips_sent        = 0;
    neighbours_checked = 0;
    strip_result_count = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_addresses(200);
    test_streaming(80);
    in_valid = 1'b0;

    // drain, then watch for stray results
    while (expected_neighbours.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);

    $display("Sent %0d strip addresses on both planes with gaps and stalls, then streaming;",
             strips_sent);
    $display("checked %0d neighbor results, %0d mismatches.", neighbours_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
